@@ sv/mmsp_pkg.sv @@
// ----------------------------------------------------------------------------
// mmsp_pkg : shared types and constants for motion model state prediction
// Fixed-point formats, item layout, queue status and CORDIC tables.
// ----------------------------------------------------------------------------
package mmsp_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DT_BITS    = 24;
    localparam int THR_BITS   = 16;
    localparam int KIND_BITS  = 2;

    // (dt * word) >> FRAC_BITS
    localparam int MULW_BITS  = WORD_BITS + DT_BITS + 1;
    localparam int PROD_BITS  = MULW_BITS - FRAC_BITS;
    // heading after advance
    localparam int ANG_BITS   = PROD_BITS + 1;
    localparam int MAG_BITS   = ANG_BITS - 1;

    // angle reduction modulo 2*pi (FRAC_BITS fraction bits)
    localparam int REM_BITS   = 19;
    localparam logic [REM_BITS-1:0] TWO_PI_F = 19'd411775;
    localparam int MOD_STEPS  = 23;

    // CORDIC in Q6.30
    localparam int Q30_BITS     = 36;
    localparam int CORDIC_ITERS = 30;
    localparam int TRIG_BITS    = 20;
    localparam int CORDIC_LAT   = 1 + MOD_STEPS + 2 + CORDIC_ITERS + 1;
    localparam logic signed [Q30_BITS-1:0] K_Q30       = 36'sd652032874;
    localparam logic signed [Q30_BITS-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [Q30_BITS-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [Q30_BITS-1:0] TWO_PI_Q30  = 36'sd6746518852;

    // arc ratio divider
    localparam int NUM_BITS = WORD_BITS + FRAC_BITS;
    localparam int QUO_BITS = NUM_BITS + 1;
    localparam int DIV_LAT  = 1 + NUM_BITS + 1;

    // back end datapath
    localparam int DIFF_BITS = TRIG_BITS + 1;
    localparam int MUL_BITS  = QUO_BITS + DIFF_BITS;
    localparam int SHF_BITS  = MUL_BITS - FRAC_BITS;
    localparam int SUM_BITS  = SHF_BITS + 1;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [THR_BITS-1:0] THR_RESET = 16'd1;

    // model kind codes on the input
    localparam logic [KIND_BITS-1:0] KIND_CV   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_CTRV = 2'd1;

    typedef enum logic [1:0] {
        MODE_CV,
        MODE_LINE,
        MODE_ARC,
        MODE_HOLD
    } t_mode;

    typedef struct packed {
        t_mode                        mode;
        logic signed [WORD_BITS-1:0]  px;
        logic signed [WORD_BITS-1:0]  py;
        logic signed [WORD_BITS-1:0]  pz;
        logic signed [WORD_BITS-1:0]  th;
        logic signed [WORD_BITS-1:0]  v;
        logic signed [WORD_BITS-1:0]  w;
        logic [DT_BITS-1:0]           dt;
    } t_item;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [CNT_BITS-1:0] count;
    } t_q_stat;

    function automatic logic signed [Q30_BITS-1:0] atan_q30(input int idx);
        logic signed [Q30_BITS-1:0] val;
        val = '0;
        case (idx)
            0:  val = 36'sd843314857;
            1:  val = 36'sd497837829;
            2:  val = 36'sd263043837;
            3:  val = 36'sd133525159;
            4:  val = 36'sd67021687;
            5:  val = 36'sd33543516;
            6:  val = 36'sd16775851;
            7:  val = 36'sd8388437;
            8:  val = 36'sd4194283;
            9:  val = 36'sd2097149;
            10: val = 36'sd1048576;
            default: val[30-idx] = 1'b1;
        endcase
        return val;
    endfunction

endpackage

@@ sv/mmsp_front.sv @@
// ----------------------------------------------------------------------------
// mmsp_front : input stage and classifier
// Accepts input beats, picks the motion mode and pushes items to the queue.
// ----------------------------------------------------------------------------
module mmsp_front import mmsp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [KIND_BITS-1:0]        i_model_kind,
    input  logic signed [WORD_BITS-1:0] i_pos_x,
    input  logic signed [WORD_BITS-1:0] i_pos_y,
    input  logic signed [WORD_BITS-1:0] i_pos_z,
    input  logic signed [WORD_BITS-1:0] i_heading,
    input  logic signed [WORD_BITS-1:0] i_speed,
    input  logic signed [WORD_BITS-1:0] i_turn_rate,
    input  logic [DT_BITS-1:0]          i_step_time,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [THR_BITS-1:0]         i_cfg_data,
    input  t_q_stat                     i_stat,
    output logic                        o_push,
    output t_item                       o_item
);

    logic [THR_BITS-1:0] r_thr;
    logic                r_f_valid;
    t_item               r_f_item;
    t_item               n_f_item;
    logic [WORD_BITS-1:0] l_wmag;
    logic                l_accept;

    assign o_cfg_ready = 1'b1;
    assign o_push      = r_f_valid && !i_stat.full;
    assign o_ready     = !r_f_valid || !i_stat.full;
    assign l_accept    = i_valid && o_ready;
    assign o_item      = r_f_item;

    assign l_wmag = i_turn_rate[WORD_BITS-1] ? WORD_BITS'(-i_turn_rate)
                                              : WORD_BITS'(i_turn_rate);

    always_comb begin
        n_f_item    = '0;
        n_f_item.px = i_pos_x;
        n_f_item.py = i_pos_y;
        n_f_item.pz = i_pos_z;
        n_f_item.th = i_heading;
        n_f_item.v  = i_speed;
        n_f_item.w  = i_turn_rate;
        n_f_item.dt = i_step_time;
        case (i_model_kind)
            KIND_CV: n_f_item.mode = MODE_CV;
            KIND_CTRV: begin
                // run straight on a small or zero turn rate
                if (i_turn_rate == '0 || l_wmag < WORD_BITS'(r_thr)) begin
                    n_f_item.mode = MODE_LINE;
                end else begin
                    n_f_item.mode = MODE_ARC;
                end
            end
            default: n_f_item.mode = MODE_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RESET;
            r_f_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (l_accept) begin
                r_f_valid <= 1'b1;
            end else if (o_push) begin
                r_f_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_accept) begin
            r_f_item <= n_f_item;
        end
    end

endmodule

@@ sv/mmsp_fifo.sv @@
// ----------------------------------------------------------------------------
// mmsp_fifo : short item queue between front and back
// First-word-fall-through register queue with full/empty/count status.
// ----------------------------------------------------------------------------
module mmsp_fifo import mmsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_data,
    input  logic    i_pop,
    output t_item   o_data,
    output t_q_stat o_stat
);

    t_item               r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_cnt;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_BITS'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/mmsp_cordic.sv @@
// ----------------------------------------------------------------------------
// mmsp_cordic : pipelined sine/cosine
// Reduces the angle modulo 2*pi, folds to +-pi/2, rotates 30 stages.
// ----------------------------------------------------------------------------
module mmsp_cordic import mmsp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [ANG_BITS-1:0]  i_angle,
    output logic signed [TRIG_BITS-1:0] o_sin,
    output logic signed [TRIG_BITS-1:0] o_cos
);

    logic [MAG_BITS-1:0]        r_rem [MOD_STEPS+1];
    logic                       r_neg [MOD_STEPS+1];
    logic signed [Q30_BITS-1:0] r_wz;
    logic signed [Q30_BITS-1:0] r_fz;
    logic                       r_fneg;
    logic signed [Q30_BITS-1:0] r_x [CORDIC_ITERS];
    logic signed [Q30_BITS-1:0] r_y [CORDIC_ITERS];
    logic signed [Q30_BITS-1:0] r_z [CORDIC_ITERS];
    logic                       r_fn [CORDIC_ITERS];
    logic signed [TRIG_BITS-1:0] r_sin;
    logic signed [TRIG_BITS-1:0] r_cos;

    logic [MAG_BITS-1:0]        l_mag;
    logic signed [Q30_BITS-1:0] l_pos;
    logic signed [Q30_BITS-1:0] l_r;
    logic signed [Q30_BITS-1:0] l_xs;
    logic signed [Q30_BITS-1:0] l_ys;

    assign l_mag = i_angle[ANG_BITS-1] ? MAG_BITS'(-i_angle) : MAG_BITS'(i_angle);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= l_mag;
            r_neg[0] <= i_angle[ANG_BITS-1];
        end
    end

    // one conditional subtract of a shifted 2*pi per stage
    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
        localparam logic [MAG_BITS-1:0] SUB = MAG_BITS'(TWO_PI_F) << (MOD_STEPS - 1 - k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= (r_rem[k] >= SUB) ? r_rem[k] - SUB : r_rem[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // remainder keeps the dividend sign, then wrap into [-pi, pi]
    assign l_pos = Q30_BITS'({r_rem[MOD_STEPS][REM_BITS-1:0], {(30-FRAC_BITS){1'b0}}});
    assign l_r   = r_neg[MOD_STEPS] ? -l_pos : l_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (l_r > PI_Q30) begin
                r_wz <= l_r - TWO_PI_Q30;
            end else if (l_r < -PI_Q30) begin
                r_wz <= l_r + TWO_PI_Q30;
            end else begin
                r_wz <= l_r;
            end
            // fold into [-pi/2, pi/2], negate both results later
            if (r_wz > HALF_PI_Q30) begin
                r_fz   <= r_wz - PI_Q30;
                r_fneg <= 1'b1;
            end else if (r_wz < -HALF_PI_Q30) begin
                r_fz   <= r_wz + PI_Q30;
                r_fneg <= 1'b1;
            end else begin
                r_fz   <= r_wz;
                r_fneg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
        localparam logic signed [Q30_BITS-1:0] AT = atan_q30(i);
        logic signed [Q30_BITS-1:0] l_x;
        logic signed [Q30_BITS-1:0] l_y;
        logic signed [Q30_BITS-1:0] l_z;
        logic                       l_n;
        if (i == 0) begin : g_first
            assign l_x = K_Q30;
            assign l_y = '0;
            assign l_z = r_fz;
            assign l_n = r_fneg;
        end else begin : g_next
            assign l_x = r_x[i-1];
            assign l_y = r_y[i-1];
            assign l_z = r_z[i-1];
            assign l_n = r_fn[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (l_z >= 0) begin
                    r_x[i] <= l_x - (l_y >>> i);
                    r_y[i] <= l_y + (l_x >>> i);
                    r_z[i] <= l_z - AT;
                end else begin
                    r_x[i] <= l_x + (l_y >>> i);
                    r_y[i] <= l_y - (l_x >>> i);
                    r_z[i] <= l_z + AT;
                end
                r_fn[i] <= l_n;
            end
        end
    end

    assign l_xs = r_x[CORDIC_ITERS-1] >>> (30 - FRAC_BITS);
    assign l_ys = r_y[CORDIC_ITERS-1] >>> (30 - FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= TRIG_BITS'(r_fn[CORDIC_ITERS-1] ? -l_xs : l_xs);
            r_sin <= TRIG_BITS'(r_fn[CORDIC_ITERS-1] ? -l_ys : l_ys);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

@@ sv/mmsp_div.sv @@
// ----------------------------------------------------------------------------
// mmsp_div : pipelined arc ratio divider
// Computes (num << FRAC_BITS) / den truncated toward zero, one bit a stage.
// ----------------------------------------------------------------------------
module mmsp_div import mmsp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_num,
    input  logic signed [WORD_BITS-1:0] i_den,
    output logic signed [QUO_BITS-1:0]  o_quo
);

    logic [NUM_BITS-1:0]  r_n [NUM_BITS+1];
    logic [WORD_BITS-1:0] r_d [NUM_BITS+1];
    logic [WORD_BITS-1:0] r_r [NUM_BITS+1];
    logic [NUM_BITS-1:0]  r_q [NUM_BITS+1];
    logic                 r_s [NUM_BITS+1];
    logic signed [QUO_BITS-1:0] r_quo;

    logic [WORD_BITS-1:0] l_nmag;
    logic [WORD_BITS-1:0] l_dmag;
    logic signed [QUO_BITS-1:0] l_qp;

    assign l_nmag = i_num[WORD_BITS-1] ? WORD_BITS'(-i_num) : WORD_BITS'(i_num);
    assign l_dmag = i_den[WORD_BITS-1] ? WORD_BITS'(-i_den) : WORD_BITS'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= {l_nmag, {FRAC_BITS{1'b0}}};
            r_d[0] <= l_dmag;
            r_r[0] <= '0;
            r_q[0] <= '0;
            r_s[0] <= i_num[WORD_BITS-1] ^ i_den[WORD_BITS-1];
        end
    end

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_step
        logic [WORD_BITS:0] l_t;
        assign l_t = {r_r[k], r_n[k][NUM_BITS-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (l_t >= {1'b0, r_d[k]}) begin
                    r_r[k+1] <= WORD_BITS'(l_t - {1'b0, r_d[k]});
                    r_q[k+1] <= {r_q[k][NUM_BITS-2:0], 1'b1};
                end else begin
                    r_r[k+1] <= l_t[WORD_BITS-1:0];
                    r_q[k+1] <= {r_q[k][NUM_BITS-2:0], 1'b0};
                end
                r_n[k+1] <= r_n[k] << 1;
                r_d[k+1] <= r_d[k];
                r_s[k+1] <= r_s[k];
            end
        end
    end

    assign l_qp = QUO_BITS'({1'b0, r_q[NUM_BITS]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= r_s[NUM_BITS] ? -l_qp : l_qp;
        end
    end

    assign o_quo = r_quo;

endmodule

@@ sv/mmsp_back.sv @@
// ----------------------------------------------------------------------------
// mmsp_back : prediction pipeline and output register
// Advances heading, runs sine/cosine and arc ratio, forms the new pose.
// ----------------------------------------------------------------------------
module mmsp_back import mmsp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_item                       i_head,
    input  t_q_stat                     i_stat,
    output logic                        o_pop,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_next_x,
    output logic signed [WORD_BITS-1:0] o_next_y,
    output logic signed [WORD_BITS-1:0] o_next_z,
    output logic signed [WORD_BITS-1:0] o_next_heading,
    output logic signed [WORD_BITS-1:0] o_next_speed,
    output logic signed [WORD_BITS-1:0] o_next_turn_rate,
    output logic                        o_saturated
);

    localparam int QD = CORDIC_LAT - DIV_LAT;

    typedef struct packed {
        t_mode                        mode;
        logic signed [WORD_BITS-1:0]  px;
        logic signed [WORD_BITS-1:0]  py;
        logic signed [WORD_BITS-1:0]  pz;
        logic signed [WORD_BITS-1:0]  v;
        logic signed [WORD_BITS-1:0]  w;
        logic signed [ANG_BITS-1:0]   nth;
        logic signed [PROD_BITS-1:0]  dv;
    } t_side;

    function automatic logic [WORD_BITS:0] sat_word(input logic signed [SUM_BITS-1:0] val);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        logic [WORD_BITS:0]         res;
        hi = SUM_BITS'(WORD_MAX);
        lo = SUM_BITS'(WORD_MIN);
        if (val > hi) begin
            res = {1'b1, WORD_MAX};
        end else if (val < lo) begin
            res = {1'b1, WORD_MIN};
        end else begin
            res = {1'b0, val[WORD_BITS-1:0]};
        end
        return res;
    endfunction

    logic l_adv;

    logic  r_b0_v;
    t_item r_b0;
    logic  r_b1_v;
    t_side r_b1;
    logic signed [WORD_BITS-1:0] r_b1_th;

    logic  r_vd [CORDIC_LAT];
    t_side r_sd [CORDIC_LAT];
    logic signed [QUO_BITS-1:0] r_qd [QD];

    logic  r_e_v;
    t_side r_e;
    logic signed [QUO_BITS-1:0]  r_e_a;
    logic signed [DIFF_BITS-1:0] r_e_bx;
    logic signed [DIFF_BITS-1:0] r_e_by;

    logic  r_p_v;
    t_side r_p;
    logic signed [SHF_BITS-1:0] r_p_dx;
    logic signed [SHF_BITS-1:0] r_p_dy;

    logic r_o_valid;
    logic signed [WORD_BITS-1:0] r_o_x;
    logic signed [WORD_BITS-1:0] r_o_y;
    logic signed [WORD_BITS-1:0] r_o_z;
    logic signed [WORD_BITS-1:0] r_o_th;
    logic signed [WORD_BITS-1:0] r_o_v;
    logic signed [WORD_BITS-1:0] r_o_w;
    logic                        r_o_sat;

    logic signed [MULW_BITS-1:0] l_wdt;
    logic signed [MULW_BITS-1:0] l_dtv;
    t_side                       n_b1;
    logic signed [TRIG_BITS-1:0] l_s1;
    logic signed [TRIG_BITS-1:0] l_c1;
    logic signed [TRIG_BITS-1:0] l_s2;
    logic signed [TRIG_BITS-1:0] l_c2;
    logic signed [QUO_BITS-1:0]  l_quo;
    logic signed [MUL_BITS-1:0]  l_mx;
    logic signed [MUL_BITS-1:0]  l_my;
    logic [WORD_BITS:0]          l_sx;
    logic [WORD_BITS:0]          l_sy;
    logic [WORD_BITS:0]          l_sth;
    logic                        l_arc;

    // whole pipeline moves unless a finished beat waits at the output
    assign l_adv = !r_o_valid || i_ready;
    assign o_pop = l_adv && !i_stat.empty;

    // stage B1: heading advance and dt*v
    assign l_wdt = r_b0.w * $signed({1'b0, r_b0.dt});
    assign l_dtv = r_b0.v * $signed({1'b0, r_b0.dt});

    always_comb begin
        n_b1      = '0;
        n_b1.mode = r_b0.mode;
        n_b1.px   = r_b0.px;
        n_b1.py   = r_b0.py;
        n_b1.pz   = r_b0.pz;
        n_b1.v    = r_b0.v;
        n_b1.w    = r_b0.w;
        n_b1.dv   = l_dtv[MULW_BITS-1:FRAC_BITS];
        case (r_b0.mode)
            MODE_LINE, MODE_ARC: begin
                n_b1.nth = ANG_BITS'(r_b0.th)
                         + ANG_BITS'($signed(l_wdt[MULW_BITS-1:FRAC_BITS]));
            end
            default: n_b1.nth = ANG_BITS'(r_b0.th);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
            r_b1_v <= 1'b0;
        end else if (l_adv) begin
            r_b0_v <= !i_stat.empty;
            r_b1_v <= r_b0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_adv) begin
            r_b0    <= i_head;
            r_b1    <= n_b1;
            r_b1_th <= r_b0.th;
        end
    end

    mmsp_cordic u_trig_now (
        .i_clk   (i_clk),
        .i_en    (l_adv),
        .i_angle (ANG_BITS'(r_b1_th)),
        .o_sin   (l_s1),
        .o_cos   (l_c1)
    );

    mmsp_cordic u_trig_next (
        .i_clk   (i_clk),
        .i_en    (l_adv),
        .i_angle (r_b1.nth),
        .o_sin   (l_s2),
        .o_cos   (l_c2)
    );

    mmsp_div u_ratio (
        .i_clk (i_clk),
        .i_en  (l_adv),
        .i_num (r_b1.v),
        .i_den (r_b1.w),
        .o_quo (l_quo)
    );

    // carry the item alongside the sine/cosine pipelines
    for (genvar d = 0; d < CORDIC_LAT; d++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[d] <= 1'b0;
            end else if (l_adv) begin
                r_vd[d] <= (d == 0) ? r_b1_v : r_vd[(d == 0) ? 0 : d-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (l_adv) begin
                r_sd[d] <= (d == 0) ? r_b1 : r_sd[(d == 0) ? 0 : d-1];
            end
        end
    end

    // line the divider result up with the trig results
    for (genvar d = 0; d < QD; d++) begin : g_qd
        always_ff @(posedge i_clk) begin
            if (l_adv) begin
                r_qd[d] <= (d == 0) ? l_quo : r_qd[(d == 0) ? 0 : d-1];
            end
        end
    end

    // stage E: operand select
    assign l_arc = (r_sd[CORDIC_LAT-1].mode == MODE_ARC);

    // stage P: scaled products, floor shift
    assign l_mx = r_e_a * r_e_bx;
    assign l_my = r_e_a * r_e_by;

    // output stage: add and clamp to the word range
    assign l_sx  = sat_word(SUM_BITS'(r_p.px) + SUM_BITS'(r_p_dx));
    assign l_sy  = sat_word(SUM_BITS'(r_p.py) + SUM_BITS'(r_p_dy));
    assign l_sth = sat_word(SUM_BITS'(r_p.nth));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v     <= 1'b0;
            r_p_v     <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (l_adv) begin
            r_e_v     <= r_vd[CORDIC_LAT-1];
            r_p_v     <= r_e_v;
            r_o_valid <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_adv) begin
            r_e <= r_sd[CORDIC_LAT-1];
            if (l_arc) begin
                r_e_a  <= r_qd[QD-1];
                r_e_bx <= DIFF_BITS'(l_s2) - DIFF_BITS'(l_s1);
                r_e_by <= DIFF_BITS'(l_c1) - DIFF_BITS'(l_c2);
            end else begin
                r_e_a  <= QUO_BITS'(r_sd[CORDIC_LAT-1].dv);
                r_e_bx <= DIFF_BITS'(l_c1);
                r_e_by <= DIFF_BITS'(l_s1);
            end

            r_p    <= r_e;
            r_p_dx <= l_mx[MUL_BITS-1:FRAC_BITS];
            r_p_dy <= l_my[MUL_BITS-1:FRAC_BITS];

            r_o_z  <= r_p.pz;
            r_o_th <= l_sth[WORD_BITS-1:0];
            case (r_p.mode)
                MODE_HOLD: begin
                    r_o_x   <= r_p.px;
                    r_o_y   <= r_p.py;
                    r_o_v   <= '0;
                    r_o_w   <= '0;
                    r_o_sat <= l_sth[WORD_BITS];
                end
                MODE_CV: begin
                    r_o_x   <= l_sx[WORD_BITS-1:0];
                    r_o_y   <= l_sy[WORD_BITS-1:0];
                    r_o_v   <= r_p.v;
                    r_o_w   <= '0;
                    r_o_sat <= l_sx[WORD_BITS] | l_sy[WORD_BITS] | l_sth[WORD_BITS];
                end
                default: begin
                    r_o_x   <= l_sx[WORD_BITS-1:0];
                    r_o_y   <= l_sy[WORD_BITS-1:0];
                    r_o_v   <= r_p.v;
                    r_o_w   <= r_p.w;
                    r_o_sat <= l_sx[WORD_BITS] | l_sy[WORD_BITS] | l_sth[WORD_BITS];
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_next_x         = r_o_x;
    assign o_next_y         = r_o_y;
    assign o_next_z         = r_o_z;
    assign o_next_heading   = r_o_th;
    assign o_next_speed     = r_o_v;
    assign o_next_turn_rate = r_o_w;
    assign o_saturated      = r_o_sat;

endmodule

@@ sv/motion_model_state_prediction_core.sv @@
// ----------------------------------------------------------------------------
// motion_model_state_prediction_core : one-step state prediction
// Constant velocity, constant turn rate and velocity, constant position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one state per beat: model kind,
//   x, y, z, heading, speed, turn rate (signed Q16.16) and step time.
//   Output channel (o_valid / i_ready) returns one predicted state per beat,
//   in input order, with o_saturated set when x, y or heading was clamped.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the turn threshold;
//   it is always ready. Write it only while the block is empty.
//   Throughput: one beat per cycle while the receiver takes results.
//   The path from input beat to output beat is set mostly by the
//   57-stage sine/cosine pipelines (angle reduction plus 30 CORDIC
//   rotations); the 50-stage ratio divider runs alongside.
//   A four-entry queue sits between the classifier and the pipeline.
//   Receiver stall: the result holds in the output register and the
//   pipeline freezes; the queue and input stage keep taking beats until
//   the queue fills, then o_ready drops.
//   Reset (synchronous, active low) empties every stage and the queue and
//   sets the turn threshold to 1.
// ----------------------------------------------------------------------------
module motion_model_state_prediction_core import mmsp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [KIND_BITS-1:0]        i_model_kind,
    input  logic signed [WORD_BITS-1:0] i_pos_x,
    input  logic signed [WORD_BITS-1:0] i_pos_y,
    input  logic signed [WORD_BITS-1:0] i_pos_z,
    input  logic signed [WORD_BITS-1:0] i_heading,
    input  logic signed [WORD_BITS-1:0] i_speed,
    input  logic signed [WORD_BITS-1:0] i_turn_rate,
    input  logic [DT_BITS-1:0]          i_step_time,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [THR_BITS-1:0]         i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_next_x,
    output logic signed [WORD_BITS-1:0] o_next_y,
    output logic signed [WORD_BITS-1:0] o_next_z,
    output logic signed [WORD_BITS-1:0] o_next_heading,
    output logic signed [WORD_BITS-1:0] o_next_speed,
    output logic signed [WORD_BITS-1:0] o_next_turn_rate,
    output logic                        o_saturated
);

    t_q_stat w_stat;
    t_item   w_push_item;
    t_item   w_head;
    logic    w_push;
    logic    w_pop;

    // classify and hold one beat ahead of the queue
    mmsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_model_kind (i_model_kind),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_heading    (i_heading),
        .i_speed      (i_speed),
        .i_turn_rate  (i_turn_rate),
        .i_step_time  (i_step_time),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_stat       (w_stat),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    // decouple the front from pipeline stalls
    mmsp_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_stat  (w_stat)
    );

    // arithmetic pipeline and output register
    mmsp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .i_stat           (w_stat),
        .o_pop            (w_pop),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_next_x         (o_next_x),
        .o_next_y         (o_next_y),
        .o_next_z         (o_next_z),
        .o_next_heading   (o_next_heading),
        .o_next_speed     (o_next_speed),
        .o_next_turn_rate (o_next_turn_rate),
        .o_saturated      (o_saturated)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= CNT_BITS'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    // a full queue that is not popped in the same cycle takes no push
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.full && !w_pop |-> !w_push)
        else $error("push into full queue");

    // a saturation flag means some clamped field sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_next_x == WORD_MAX || o_next_x == WORD_MIN ||
             o_next_y == WORD_MAX || o_next_y == WORD_MIN ||
             o_next_heading == WORD_MAX || o_next_heading == WORD_MIN))
        else $error("saturation flag without clamped value");

endmodule
